/* hw/rtl/pgm_header_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// pgm header parser assertion macros
// shared concurrent assertion forms for the header parser rtl
// ----------------------------------------------------------------------------
`ifndef PGM_HEADER_PARSER_UNIT_MACROS_SVH
`define PGM_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PHU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define PHU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pgm_hdr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm header parser package
// item types, status and phase codes, character constants, and register constants
// ----------------------------------------------------------------------------
package pgm_hdr_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] header_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] width_out;
        logic [15:0] height_out;
        logic [15:0] max_value_out;
    } t_out_item;

    localparam logic       CMD_BYTE    = 1'b0;
    localparam logic       CMD_RESTART = 1'b1;

    localparam logic [1:0] ST_GOOD      = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_WIDTH  = 3'd1;
    localparam logic [2:0] PH_HEIGHT = 3'd2;
    localparam logic [2:0] PH_MAXVAL = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [15:0] NUM_MAX = 16'hffff;

    localparam logic [15:0] RST_EXP_WIDTH  = 16'd910;
    localparam logic [15:0] RST_EXP_HEIGHT = 16'd1400;

    localparam logic REG_EXP_WIDTH  = 1'b0;
    localparam logic REG_EXP_HEIGHT = 1'b1;

endpackage

/* hw/rtl/pgm_header_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm header parser unit
// Parses a P5 PGM header one byte per item. The block accepts one item every
// clock cycle while its skid entry is empty: the whole per-byte update (comment
// skipping, token split, magic check, decimal accumulate with saturation at
// 65535) is one register stage on the parser state. A result leaves through an
// output register, formed from the separator that ends the fourth token (or
// the bad magic token); a one-entry skid holds a second result while the output
// stalls, and input is held off only while that skid entry is occupied.
// Command 1 restarts the parser and keeps the expected width and height
// registers (APB, byte address 0 and 4; reset 910 and 1400).
// ----------------------------------------------------------------------------
`include "pgm_header_parser_unit_macros.svh"

module pgm_header_parser_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  pgm_hdr_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output pgm_hdr_pkg::t_out_item o_out_item,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_exp_width;
    logic [15:0] r_exp_height;

    logic [2:0]  r_phase,     n_phase;
    logic        r_in_comment, n_in_comment;
    logic [1:0]  r_tok_len,   n_tok_len;
    logic        r_magic_ok,  n_magic_ok;
    logic [15:0] r_num,       n_num;
    logic        r_dig_stop,  n_dig_stop;
    logic [15:0] r_saved_w,   n_saved_w;
    logic [15:0] r_saved_h,   n_saved_h;

    logic                   r_out_valid;
    pgm_hdr_pkg::t_out_item r_out_item;
    logic                   r_skid_valid;
    pgm_hdr_pkg::t_out_item r_skid_item;

    logic                   w_accept;
    logic                   w_cfg_wr;
    logic [7:0]             w_byte;
    logic                   w_is_sep;
    logic                   w_is_digit;
    logic [19:0]            w_acc;
    logic [15:0]            w_acc_sat;
    logic                   w_res_valid;
    pgm_hdr_pkg::t_out_item w_res;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == pgm_hdr_pkg::REG_EXP_HEIGHT) ? {16'd0, r_exp_height}
                                                                : {16'd0, r_exp_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_width  <= pgm_hdr_pkg::RST_EXP_WIDTH;
            r_exp_height <= pgm_hdr_pkg::RST_EXP_HEIGHT;
        end else if (w_cfg_wr) begin
            if (paddr[2] == pgm_hdr_pkg::REG_EXP_HEIGHT) begin
                r_exp_height <= pwdata[15:0];
            end else begin
                r_exp_width <= pwdata[15:0];
            end
        end
    end

    // input side
    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_byte     = i_in_item.header_byte;
    assign w_is_sep   = (w_byte == pgm_hdr_pkg::CH_SPACE) || (w_byte == pgm_hdr_pkg::CH_TAB)
                     || (w_byte == pgm_hdr_pkg::CH_NL);
    assign w_is_digit = (w_byte >= pgm_hdr_pkg::CH_0) && (w_byte <= pgm_hdr_pkg::CH_9);

    // value * 10 + digit
    assign w_acc     = {1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0} + {16'd0, w_byte[3:0]};
    assign w_acc_sat = (w_acc > {4'd0, pgm_hdr_pkg::NUM_MAX}) ? pgm_hdr_pkg::NUM_MAX
                                                               : w_acc[15:0];

    always_comb begin
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        n_tok_len    = r_tok_len;
        n_magic_ok   = r_magic_ok;
        n_num        = r_num;
        n_dig_stop   = r_dig_stop;
        n_saved_w    = r_saved_w;
        n_saved_h    = r_saved_h;
        w_res_valid  = 1'b0;
        w_res        = '0;
        if (w_accept) begin
            if (i_in_item.command == pgm_hdr_pkg::CMD_RESTART) begin
                n_phase      = pgm_hdr_pkg::PH_MAGIC;
                n_in_comment = 1'b0;
                n_tok_len    = 2'd0;
                n_magic_ok   = 1'b1;
                n_num        = 16'd0;
                n_dig_stop   = 1'b0;
                n_saved_w    = 16'd0;
                n_saved_h    = 16'd0;
            end else if (!r_phase[2]) begin
                if (r_in_comment) begin
                    if (w_byte == pgm_hdr_pkg::CH_NL) begin
                        n_in_comment = 1'b0;
                    end
                end else if (w_byte == pgm_hdr_pkg::CH_HASH) begin
                    n_in_comment = 1'b1;
                end else if (w_is_sep) begin
                    if (r_tok_len != 2'd0) begin
                        case (r_phase)
                            pgm_hdr_pkg::PH_MAGIC: begin
                                if (!r_magic_ok || r_tok_len != 2'd2) begin
                                    w_res_valid  = 1'b1;
                                    w_res.status = pgm_hdr_pkg::ST_BAD_MAGIC;
                                    n_phase      = pgm_hdr_pkg::PH_DONE;
                                end else begin
                                    n_phase = pgm_hdr_pkg::PH_WIDTH;
                                end
                            end
                            pgm_hdr_pkg::PH_WIDTH: begin
                                n_saved_w = r_num;
                                n_phase   = pgm_hdr_pkg::PH_HEIGHT;
                            end
                            pgm_hdr_pkg::PH_HEIGHT: begin
                                n_saved_h = r_num;
                                n_phase   = pgm_hdr_pkg::PH_MAXVAL;
                            end
                            default: begin
                                w_res_valid         = 1'b1;
                                w_res.status        = (r_saved_w == r_exp_width
                                                    && r_saved_h == r_exp_height)
                                                    ? pgm_hdr_pkg::ST_GOOD
                                                    : pgm_hdr_pkg::ST_MISMATCH;
                                w_res.width_out     = r_saved_w;
                                w_res.height_out    = r_saved_h;
                                w_res.max_value_out = r_num;
                                n_phase             = pgm_hdr_pkg::PH_DONE;
                            end
                        endcase
                        n_tok_len  = 2'd0;
                        n_num      = 16'd0;
                        n_dig_stop = 1'b0;
                    end
                end else begin
                    if (r_phase == pgm_hdr_pkg::PH_MAGIC) begin
                        if (!((r_tok_len == 2'd0 && w_byte == pgm_hdr_pkg::CH_P)
                           || (r_tok_len == 2'd1 && w_byte == pgm_hdr_pkg::CH_5))) begin
                            n_magic_ok = 1'b0;
                        end
                    end else if (!r_dig_stop && w_is_digit) begin
                        n_num = w_acc_sat;
                    end else begin
                        n_dig_stop = 1'b1;
                    end
                    if (r_tok_len != 2'd3) begin
                        n_tok_len = r_tok_len + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= pgm_hdr_pkg::PH_MAGIC;
            r_in_comment <= 1'b0;
            r_tok_len    <= 2'd0;
            r_magic_ok   <= 1'b1;
            r_num        <= 16'd0;
            r_dig_stop   <= 1'b0;
            r_saved_w    <= 16'd0;
            r_saved_h    <= 16'd0;
        end else begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
            r_tok_len    <= n_tok_len;
            r_magic_ok   <= n_magic_ok;
            r_num        <= n_num;
            r_dig_stop   <= n_dig_stop;
            r_saved_w    <= n_saved_w;
            r_saved_h    <= n_saved_h;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_res_valid;
            end
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out_item <= r_skid_valid ? r_skid_item : w_res;
        end else if (w_res_valid) begin
            r_skid_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PHU_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held without an output item")
    `PHU_ASSERT_NOW(a_result_ends_parse, i_clk, i_rst_n, w_res_valid,
        n_phase == pgm_hdr_pkg::PH_DONE, "result given without entering done phase")
    `PHU_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n,
        w_accept && i_in_item.command == pgm_hdr_pkg::CMD_RESTART,
        r_phase == pgm_hdr_pkg::PH_MAGIC && !r_in_comment && r_tok_len == 2'd0,
        "restart did not clear parser state")
    `PHU_ASSERT_NOW(a_bad_magic_zero, i_clk, i_rst_n,
        r_out_valid && r_out_item.status == pgm_hdr_pkg::ST_BAD_MAGIC,
        r_out_item.width_out == 16'd0 && r_out_item.height_out == 16'd0
        && r_out_item.max_value_out == 16'd0,
        "bad magic item carries nonzero values")

endmodule
